FILE: src/eamt_pkg.sv
// Package for the explicit address mapping table: payload structs, action
// and status codes, prefix mask helpers. No dependencies.
package eamt_pkg;

  localparam int unsigned DefEntries = 64;

  localparam logic [2:0] ActAdd   = 3'd0;
  localparam logic [2:0] ActRem   = 3'd1;
  localparam logic [2:0] ActX64   = 3'd2;
  localparam logic [2:0] ActX46   = 3'd3;
  localparam logic [2:0] ActHas6  = 3'd4;
  localparam logic [2:0] ActHas4  = 3'd5;
  localparam logic [2:0] ActFlush = 3'd6;
  localparam logic [2:0] ActUndef = 3'd7;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StExists   = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] addr6_hi;
    logic [63:0] addr6_lo;
    logic [7:0]  len6;
    logic [31:0] addr4;
    logic [5:0]  len4;
    logic        force_req;
    logic        use6;
    logic        use4;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [63:0] out_addr6_hi;
    logic [63:0] out_addr6_lo;
    logic [31:0] out_addr4;
    logic [6:0]  entry_total;
  } out_item_t;

  // Prefix mask, MSB first; len above 128 gives all ones.
  function automatic logic [127:0] mask6(input logic [7:0] len);
    logic [127:0] m;
    m = '0;
    if (len >= 8'd128) m = '1;
    else if (len != 8'd0) m = ~({128{1'b1}} >> len[6:0]);
    return m;
  endfunction

  function automatic logic [31:0] mask4(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len >= 6'd32) m = '1;
    else if (len != 6'd0) m = ~(32'hFFFF_FFFF >> len[4:0]);
    return m;
  endfunction

endpackage

FILE: src/explicit_address_mapping_table_unit.sv
// Explicit address mapping table top level: entry memory, scan sequencer
// and result register. Depends on eamt_pkg.
//
// Usage: an item on in_item (valid/ready) carries one action: add, remove,
// translate 6->4 or 4->6, contains query or flush. One result item per
// input item leaves on out_item (valid/ready).
// Each search action scans the entry memory one entry per cycle, one
// memory read port. Add runs two scans (longest match, then exact match
// and a free slot search). Translation then reads the winning entry.
// Flush and an unknown action skip the scan, and a rejected add or remove
// ends before its scan starts. One item is handled at a time; in_ready is
// low meanwhile, and the next item is taken only after the result is
// accepted.
// Reset clears all valid bits and the entry count; the table starts empty
// and the entry memory itself holds no reset.
// When the receiver stalls, the result is held in the output register and
// the next item is not taken until it is accepted.
module explicit_address_mapping_table_unit #(
  parameter int unsigned TABLE_ENTRIES = eamt_pkg::DefEntries
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  eamt_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output eamt_pkg::out_item_t out_item
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW:0] LastIdx = (IW + 1)'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_SCAN2 = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_XLAT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Entry memory, one row per entry.
  typedef struct packed {
    logic [127:0] p6;
    logic [7:0]   l6;
    logic [31:0]  p4;
    logic [5:0]   l4;
  } row_t;

  row_t mem [TABLE_ENTRIES];
  row_t rd;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0] count;

  logic [2:0]  state;
  eamt_pkg::in_item_t req;
  logic [IW:0] idx;      // read address of the scan
  logic [IW:0] pidx;     // address of the row now in rd
  logic        pvld;     // rd holds a scan row
  // search results
  logic        f6, f4, fe6, fe4, ffree;
  logic [IW-1:0] b6, b4, e6, e4, free;
  logic [7:0]  bl6;
  logic [5:0]  bl4;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  eamt_pkg::out_item_t res;

  logic [127:0] a6;
  logic [IW-1:0] pi;
  logic         rvalid;
  logic         m6, m4, x6, x4;

  assign a6  = {req.addr6_hi, req.addr6_lo};
  assign pi  = pidx[IW-1:0];
  assign rvalid = valid[pi];
  assign m6 = rvalid && (((a6 ^ rd.p6) & eamt_pkg::mask6(rd.l6)) == '0);
  assign m4 = rvalid && (((req.addr4 ^ rd.p4) & eamt_pkg::mask4(rd.l4)) == '0);
  assign x6 = rvalid && rd.l6 == req.len6 &&
              (((a6 ^ rd.p6) & eamt_pkg::mask6(req.len6)) == '0);
  assign x4 = rvalid && rd.l4 == req.len4 &&
              (((req.addr4 ^ rd.p4) & eamt_pkg::mask4(req.len4)) == '0);

  assign in_ready  = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    rd <= mem[idx[IW-1:0]];
    if (wr_en) mem[wr_addr] <= '{p6: a6, l6: req.len6, p4: req.addr4, l4: req.len4};
  end

  // Early checks for an add or a remove, from the request alone.
  logic add_bad;
  logic rem_bad;
  always_comb begin
    add_bad = (req.len6 > 8'd128) || (req.len4 > 6'd32) ||
              ((a6 & ~eamt_pkg::mask6(req.len6)) != '0) ||
              ((req.addr4 & ~eamt_pkg::mask4(req.len4)) != '0);
    if (!add_bad && ((9'd32 - {3'd0, req.len4}) > (9'd128 - {1'b0, req.len6})))
      add_bad = 1'b1;
    rem_bad = (!req.use6 && !req.use4) || (req.use6 && req.len6 > 8'd128) ||
              (req.use4 && req.len4 > 6'd32);
  end

  logic [7:0]  sh;
  logic [127:0] sfx6;
  logic [5:0]  suf;
  logic [127:0] ins;
  always_comb begin
    sfx6 = a6 << rd.l6;
    suf  = 6'd32 - rd.l4;
    sh   = 8'd128 - rd.l6 - {2'd0, suf};
    ins  = {96'd0, req.addr4 & ~eamt_pkg::mask4(rd.l4)} << sh;
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
      out_valid <= 1'b0;
      pvld <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_item;
            idx <= '0;
            pvld <= 1'b0;
            f6 <= 1'b0; f4 <= 1'b0; fe6 <= 1'b0; fe4 <= 1'b0; ffree <= 1'b0;
            bl6 <= '0; bl4 <= '0;
            res <= '0;
            state <= S_SCAN1;
            if (in_item.action == eamt_pkg::ActFlush) begin
              valid <= '0;
              count <= '0;
              state <= S_OUT;
            end else if (in_item.action == eamt_pkg::ActRem) begin
              state <= S_SCAN2;
            end else if (in_item.action == eamt_pkg::ActUndef) begin
              res.status <= eamt_pkg::StInvalid;
              state <= S_OUT;
            end
          end
        end
        S_SCAN1, S_SCAN2: begin
          if (!pvld && state == S_SCAN1 && req.action == eamt_pkg::ActAdd && add_bad) begin
            res.status <= eamt_pkg::StInvalid;
            state <= S_OUT;
          end else if (!pvld && state == S_SCAN2 && req.action == eamt_pkg::ActRem &&
                       rem_bad) begin
            res.status <= eamt_pkg::StInvalid;
            state <= S_OUT;
          end else begin
            if (idx <= LastIdx) idx <= idx + 1'b1;
            pidx <= idx;
            pvld <= (idx <= LastIdx);
            if (pvld) begin
              if (state == S_SCAN1) begin
                if (m6 && (!f6 || rd.l6 > bl6)) begin f6 <= 1'b1; b6 <= pi; bl6 <= rd.l6; end
                if (m4 && (!f4 || rd.l4 > bl4)) begin f4 <= 1'b1; b4 <= pi; bl4 <= rd.l4; end
              end else begin
                if (x6 && !fe6) begin fe6 <= 1'b1; e6 <= pi; end
                if (x4 && !fe4) begin fe4 <= 1'b1; e4 <= pi; end
                if (!rvalid && !ffree) begin ffree <= 1'b1; free <= pi; end
              end
              if (pidx == LastIdx) begin
                pvld <= 1'b0;
                idx <= '0;
                state <= S_OUT;
                if (state == S_SCAN1) begin
                  case (req.action)
                    eamt_pkg::ActAdd: state <= S_SCAN2;
                    eamt_pkg::ActX64, eamt_pkg::ActX46: state <= S_READ;
                    default: state <= S_OUT;
                  endcase
                end
              end
            end
          end
        end
        S_READ: begin
          // Point the read port at the winning entry.
          idx <= {1'b0, (req.action == eamt_pkg::ActX64) ? b6 : b4};
          state <= S_XLAT;
          pidx <= '0;
        end
        S_XLAT: begin
          if (pidx == '0) pidx <= (IW + 1)'(1);
          else begin
            state <= S_OUT;
            pidx <= '0;
          end
        end
        S_OUT: begin
          if (!out_valid) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // Resolve the action at the end of its work.
      if (state == S_SCAN1 && pvld && pidx == LastIdx) begin
        case (req.action)
          eamt_pkg::ActHas6: res.hit <= f6 || (m6 && 1'b1);
          eamt_pkg::ActHas4: res.hit <= f4 || m4;
          eamt_pkg::ActX64: if (!(f6 || m6)) begin
              res.status <= eamt_pkg::StNotFound; state <= S_OUT;
            end
          eamt_pkg::ActX46: if (!(f4 || m4)) begin
              res.status <= eamt_pkg::StNotFound; state <= S_OUT;
            end
          default: ;
        endcase
      end
      if (state == S_SCAN2 && pvld && pidx == LastIdx) begin
        if (req.action == eamt_pkg::ActAdd) begin
          if ((f6 && (bl6 == req.len6 || !req.force_req)) ||
              (f4 && (bl4 == req.len4 || !req.force_req)) ||
              fe6 || x6 || fe4 || x4)
            res.status <= eamt_pkg::StExists;
          else if (!ffree && rvalid)
            res.status <= eamt_pkg::StFull;
          else begin
            wr_en <= 1'b1;
            wr_addr <= ffree ? free : pi;
            valid[ffree ? free : pi] <= 1'b1;
            count <= count + 1'b1;
          end
        end else begin
          if ((req.use6 && !(fe6 || x6)) || (req.use4 && !(fe4 || x4)) ||
              (req.use6 && req.use4 && (fe6 ? e6 : pi) != (fe4 ? e4 : pi)))
            res.status <= eamt_pkg::StNotFound;
          else begin
            valid[req.use6 ? (fe6 ? e6 : pi) : (fe4 ? e4 : pi)] <= 1'b0;
            if (count != '0) count <= count - 1'b1;
          end
        end
      end
      if (state == S_XLAT && pidx != '0) begin
        res.hit <= 1'b1;
        if (req.action == eamt_pkg::ActX64) begin
          res.out_addr4 <= rd.p4 | ((suf == 6'd0) ? 32'd0 :
                           32'(sfx6[127:96] >> (6'd32 - suf)));
        end else begin
          res.out_addr6_hi <= rd.p6[127:64] | ins[127:64];
          res.out_addr6_lo <= rd.p6[63:0] | ins[63:0];
        end
      end
      if (state == S_OUT && !out_valid) out_valid <= 1'b1;
    end
  end

  always_comb begin
    out_item = res;
    out_item.entry_total = 7'(count);
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_IDLE || state == S_OUT)
    else $error("result shown during a scan");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_ENTRIES))
    else $error("entry count past table size");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(count))
    else $error("count changed under a stalled result");

endmodule

FILE: test/tb.sv
// Testbench for explicit_address_mapping_table_unit: drives add, remove,
// translate, contains and flush items and checks each result against an
// in-bench prediction of the mapping table. Depends on eamt_pkg.
module tb;

  localparam int Depth = eamt_pkg::DefEntries;
  localparam int ItemCount = 1800;
  localparam longint CycleLimit = 64'd3_000_000;

  class mapping_scoreboard;
    bit              used[Depth];
    logic [127:0]    pfx6[Depth];
    logic [7:0]      plen6[Depth];
    logic [31:0]     pfx4[Depth];
    logic [5:0]      plen4[Depth];
    int              live;
    eamt_pkg::out_item_t pending[$];
    int              errors;

    function void clear();
      foreach (used[i]) used[i] = 1'b0;
      live = 0;
    endfunction

    function logic [127:0] m6(int len);
      if (len >= 128) return '1;
      if (len == 0) return '0;
      return ~({128{1'b1}} >> len);
    endfunction

    function logic [31:0] m4(int len);
      if (len >= 32) return '1;
      if (len == 0) return '0;
      return ~(32'hFFFF_FFFF >> len);
    endfunction

    function int longest6(logic [127:0] a);
      int best;
      best = -1;
      for (int i = 0; i < Depth; i++)
        if (used[i] && ((a ^ pfx6[i]) & m6(int'(plen6[i]))) == 0)
          if (best < 0 || plen6[i] > plen6[best]) best = i;
      return best;
    endfunction

    function int longest4(logic [31:0] a);
      int best;
      best = -1;
      for (int i = 0; i < Depth; i++)
        if (used[i] && ((a ^ pfx4[i]) & m4(int'(plen4[i]))) == 0)
          if (best < 0 || plen4[i] > plen4[best]) best = i;
      return best;
    endfunction

    function int same6(logic [127:0] a, int len);
      for (int i = 0; i < Depth; i++)
        if (used[i] && plen6[i] == len && ((a ^ pfx6[i]) & m6(len)) == 0) return i;
      return -1;
    endfunction

    function int same4(logic [31:0] a, int len);
      for (int i = 0; i < Depth; i++)
        if (used[i] && plen4[i] == len && ((a ^ pfx4[i]) & m4(len)) == 0) return i;
      return -1;
    endfunction

    function logic [2:0] add_entry(logic [127:0] a6, int l6, logic [31:0] a4, int l4,
                                   bit frc);
      int e;
      if (l6 > 128 || l4 > 32) return eamt_pkg::StInvalid;
      if ((a6 & ~m6(l6)) != 0 || (a4 & ~m4(l4)) != 0) return eamt_pkg::StInvalid;
      if (32 - l4 > 128 - l6) return eamt_pkg::StInvalid;
      e = longest6(a6);
      if (e >= 0 && (plen6[e] == l6 || !frc)) return eamt_pkg::StExists;
      e = longest4(a4);
      if (e >= 0 && (plen4[e] == l4 || !frc)) return eamt_pkg::StExists;
      if (same6(a6, l6) >= 0 || same4(a4, l4) >= 0) return eamt_pkg::StExists;
      for (int i = 0; i < Depth; i++)
        if (!used[i]) begin
          used[i] = 1'b1; pfx6[i] = a6; plen6[i] = 8'(l6); pfx4[i] = a4;
          plen4[i] = 6'(l4);
          live++;
          return eamt_pkg::StOk;
        end
      return eamt_pkg::StFull;
    endfunction

    function logic [2:0] remove_entry(eamt_pkg::in_item_t it);
      int i6, i4;
      i6 = -1; i4 = -1;
      if (!it.use6 && !it.use4) return eamt_pkg::StInvalid;
      if ((it.use6 && it.len6 > 128) || (it.use4 && it.len4 > 32)) return eamt_pkg::StInvalid;
      if (it.use6) begin
        i6 = same6({it.addr6_hi, it.addr6_lo}, int'(it.len6));
        if (i6 < 0) return eamt_pkg::StNotFound;
      end
      if (it.use4) begin
        i4 = same4(it.addr4, int'(it.len4));
        if (i4 < 0) return eamt_pkg::StNotFound;
      end
      if (it.use6 && it.use4 && i6 != i4) return eamt_pkg::StNotFound;
      used[it.use6 ? i6 : i4] = 1'b0;
      if (live > 0) live--;
      return eamt_pkg::StOk;
    endfunction

    function void note_input(eamt_pkg::in_item_t it);
      eamt_pkg::out_item_t r;
      logic [127:0] a6, sh;
      int e, suf;
      r = '0;
      a6 = {it.addr6_hi, it.addr6_lo};
      case (it.action)
        eamt_pkg::ActAdd:
          r.status = add_entry(a6, int'(it.len6), it.addr4, int'(it.len4), it.force_req);
        eamt_pkg::ActRem: r.status = remove_entry(it);
        eamt_pkg::ActX64: begin
          e = longest6(a6);
          if (e < 0) r.status = eamt_pkg::StNotFound;
          else begin
            suf = 32 - plen4[e];
            sh = a6 << plen6[e];
            r.out_addr4 = pfx4[e] | ((suf != 0) ? 32'(sh[127:96] >> (32 - suf)) : 32'd0);
            r.hit = 1'b1;
          end
        end
        eamt_pkg::ActX46: begin
          e = longest4(it.addr4);
          if (e < 0) r.status = eamt_pkg::StNotFound;
          else begin
            suf = 32 - plen4[e];
            sh = 128'(it.addr4 & ~m4(int'(plen4[e]))) << (128 - plen6[e] - suf);
            {r.out_addr6_hi, r.out_addr6_lo} = pfx6[e] | sh;
            r.hit = 1'b1;
          end
        end
        eamt_pkg::ActHas6: r.hit = longest6(a6) >= 0;
        eamt_pkg::ActHas4: r.hit = longest4(it.addr4) >= 0;
        eamt_pkg::ActFlush: clear();
        default: r.status = eamt_pkg::StInvalid;
      endcase
      r.entry_total = 7'(live);
      pending.push_back(r);
    endfunction

    task check_result(eamt_pkg::out_item_t got);
      eamt_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) report($sformatf("status %0d exp %0d", got.status, exp.status));
      if (got.hit != exp.hit) report($sformatf("hit %0d exp %0d", got.hit, exp.hit));
      if (got.out_addr6_hi != exp.out_addr6_hi || got.out_addr6_lo != exp.out_addr6_lo)
        report($sformatf("addr6 %h%h exp %h%h", got.out_addr6_hi, got.out_addr6_lo,
                         exp.out_addr6_hi, exp.out_addr6_lo));
      if (got.out_addr4 != exp.out_addr4)
        report($sformatf("addr4 %h exp %h", got.out_addr4, exp.out_addr4));
      if (got.entry_total != exp.entry_total)
        report($sformatf("total %0d exp %0d", got.entry_total, exp.entry_total));
    endtask

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  eamt_pkg::in_item_t in_item;
  eamt_pkg::out_item_t out_item;
  mapping_scoreboard board;
  longint cycles;
  bit stall_hold;

  // Prefix pools keep random adds hitting each other.
  logic [127:0] pool6[16];
  int           pool6_len[16];
  logic [31:0]  pool4[16];
  int           pool4_len[16];

  explicit_address_mapping_table_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) board.check_result(out_item);
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls in runs; some stretches never stall.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b1;
    else if ($urandom_range(0, 15) == 0) stall_hold <= ~stall_hold;
    else out_ready <= stall_hold ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic send(eamt_pkg::in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [127:0] rnd128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic eamt_pkg::in_item_t make_add(logic [127:0] a6, int l6, logic [31:0] a4,
                                                  int l4, bit frc);
    eamt_pkg::in_item_t it;
    it = '0;
    it.action = eamt_pkg::ActAdd;
    {it.addr6_hi, it.addr6_lo} = a6 & board.m6(l6);
    it.len6 = 8'(l6);
    it.addr4 = a4 & board.m4(l4);
    it.len4 = 6'(l4);
    it.force_req = frc;
    return it;
  endfunction

  function automatic eamt_pkg::in_item_t rand_item();
    eamt_pkg::in_item_t it;
    logic [255:0] raw;
    int k, l6, l4, sel;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, 15);
    if (sel < 10) begin
      raw = {$urandom, rnd128(), $urandom, $urandom, $urandom};
      it = raw[$bits(eamt_pkg::in_item_t)-1:0];
      if ($urandom_range(0, 1)) it.action = 3'($urandom_range(0, 7));
    end else if (sel < 40) begin
      l4 = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32) : pool4_len[k];
      l6 = $urandom_range(0, 3) == 0 ? $urandom_range(96, 128) : pool6_len[k];
      if (32 - l4 > 128 - l6) l6 = 96 + l4;
      it = make_add(pool6[k] | (rnd128() >> l6), l6,
                    pool4[k] | ($urandom >> pool4_len[k]), l4, 1'($urandom_range(0, 1)));
    end else if (sel < 55) begin
      it = '0;
      it.action = eamt_pkg::ActRem;
      k = $urandom_range(0, Depth - 1);
      if (board.used[k] && $urandom_range(0, 3) != 0) begin
        {it.addr6_hi, it.addr6_lo} = board.pfx6[k] | (rnd128() >> board.plen6[k]);
        it.len6 = board.plen6[k];
        it.addr4 = board.pfx4[k] | ($urandom >> board.plen4[k]);
        it.len4 = board.plen4[k];
      end else begin
        {it.addr6_hi, it.addr6_lo} = pool6[k % 16];
        it.len6 = 8'(pool6_len[k % 16]);
        it.addr4 = pool4[k % 16];
        it.len4 = 6'(pool4_len[k % 16]);
      end
      it.use6 = 1'($urandom_range(0, 1));
      it.use4 = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) != 0 && !it.use6) it.use4 = 1'b1;
    end else if (sel < 99) begin
      it = '0;
      it.action = 3'($urandom_range(eamt_pkg::ActX64, eamt_pkg::ActHas4));
      {it.addr6_hi, it.addr6_lo} = pool6[k] | (rnd128() >> pool6_len[k]);
      it.addr4 = pool4[k] | ($urandom >> pool4_len[k]);
      if ($urandom_range(0, 7) == 0) begin
        {it.addr6_hi, it.addr6_lo} = rnd128();
        it.addr4 = $urandom;
      end
    end else begin
      it = '0;
      it.action = eamt_pkg::ActFlush;
    end
    return it;
  endfunction

  initial begin
    eamt_pkg::in_item_t it;
    int burst;
    board = new();
    board.clear();
    cycles = 0;
    stall_hold = 0;
    rst = 1;
    in_valid = 0;
    in_item = '0;
    out_ready = 1;
    for (int i = 0; i < 16; i++) begin
      pool6_len[i] = $urandom_range(32, 128);
      pool6[i] = rnd128() & board.m6(pool6_len[i]);
      pool4_len[i] = $urandom_range(0, 32);
      if (32 - pool4_len[i] > 128 - pool6_len[i]) pool6_len[i] = 96 + pool4_len[i];
      pool6[i] = pool6[i] & board.m6(pool6_len[i]);
      pool4[i] = $urandom & board.m4(pool4_len[i]);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: lengths at the extremes, every action, each rejection.
    send(make_add('0, 0, '0, 0, 0));
    it = '0; it.action = eamt_pkg::ActX64; {it.addr6_hi, it.addr6_lo} = '1; send(it);
    it = '0; it.action = eamt_pkg::ActX46; it.addr4 = '1; send(it);
    send(make_add('1, 128, '1, 32, 1));
    send(make_add('1, 128, '1, 32, 0));
    send(make_add({128{1'b1}}, 96, 32'hFFFF_0000, 16, 1));
    send(make_add('0, 0, '0, 0, 0));
    it = make_add('0, 129, '0, 0, 0); send(it);
    it = make_add('0, 0, '0, 33, 0); it.len4 = 6'd33; send(it);
    it = make_add('0, 100, '0, 0, 0); send(it);
    it = make_add('0, 8, '0, 8, 0); it.addr6_lo = 64'd1; send(it);
    it = make_add('0, 8, '0, 8, 0); it.addr4 = 32'd1; send(it);
    it = '0; it.action = eamt_pkg::ActHas6; {it.addr6_hi, it.addr6_lo} = '1; send(it);
    it = '0; it.action = eamt_pkg::ActHas4; it.addr4 = 32'h1234_5678; send(it);
    it = '0; it.action = eamt_pkg::ActX64; {it.addr6_hi, it.addr6_lo} = {128{1'b1}}; send(it);
    it = '0; it.action = eamt_pkg::ActX46; it.addr4 = 32'hFFFF_ABCD; send(it);
    it = '0; it.action = eamt_pkg::ActRem; send(it);
    it = '0; it.action = eamt_pkg::ActRem; it.use6 = 1'b1; it.len6 = 8'd200; send(it);
    it = '0; it.action = eamt_pkg::ActRem; it.use4 = 1'b1; it.len4 = 6'd40; send(it);
    it = '0; it.action = eamt_pkg::ActRem; it.use6 = 1'b1; it.use4 = 1'b1;
    it.len6 = 8'd0; it.len4 = 6'd32;
    it.addr4 = '1; send(it);
    it = '0; it.action = eamt_pkg::ActRem; it.use6 = 1'b1; it.len6 = 8'd128;
    {it.addr6_hi, it.addr6_lo} = '1; send(it);
    it = '0; it.action = eamt_pkg::ActUndef; send(it);
    it = '0; it.action = eamt_pkg::ActFlush; send(it);
    // Fill the table to hit status full.
    for (int i = 0; i < Depth + 2; i++) send(make_add(128'(i) << 32, 96, 32'(i), 32, 0));
    for (int i = 0; i < Depth + 2; i++) send(make_add({32'(i), 96'd0}, 32, 32'(i), 32, 1));
    it = '0; it.action = eamt_pkg::ActFlush; send(it);

    for (int n = 0; n < ItemCount; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        send(rand_item());
        n++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
    end

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: explicit_address_mapping_table_unit.f
src/eamt_pkg.sv
src/explicit_address_mapping_table_unit.sv
test/tb.sv
